// ===== rtl/rmc_pkg.sv =====
package rmc_pkg;

    localparam int CAPTURE_LEN = 6;

    localparam logic [7:0] COMMA_CHAR = 8'h2C;
    localparam logic [7:0] ZERO_CHAR  = 8'h30;
    localparam logic [7:0] NINE_CHAR  = 8'h39;
    localparam logic [4:0] TIME_FIELD = 5'd1;
    localparam logic [4:0] DATE_FIELD = 5'd9;
    localparam logic [7:0] YEAR_OFFSET = 8'd100;

    typedef enum logic [1:0] {
        STATUS_OK         = 2'd0,
        STATUS_TIME_SHORT = 2'd1,
        STATUS_DATE_SHORT = 2'd2
    } status_t;

    // One finished sentence as handed from the parser to the converter.
    typedef struct packed {
        logic [CAPTURE_LEN-1:0][7:0] time_chars;
        logic [CAPTURE_LEN-1:0][7:0] date_chars;
        logic                        time_full;
        logic                        date_full;
    } record_t;

endpackage

// ===== rtl/nmea_rmc_time_extractor.sv =====
// NMEA RMC time/date extractor. Feed one sentence byte per transfer with
// s_last on the final byte; that byte yields one result transfer holding the
// status and the decoded hour, minute, second, day, zero-based month and
// years since 1900. Bytes are taken one per cycle while s_ready is high,
// with no gaps between sentences; a result passes through the queue and
// the output register before it appears on the m_ side. A two-entry queue
// sits between the parser and the converter, so s_ready drops only while
// the queue holds two finished results, left there by m_ready held low.
module nmea_rmc_time_extractor
    import rmc_pkg::*;
#(
    parameter int MAX_FIELDS = 16,
    parameter int FIELD_LEN  = 16
) (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              s_valid,
    output logic              s_ready,
    input  logic [7:0]        s_character,
    input  logic              s_last,
    output logic              m_valid,
    input  logic              m_ready,
    output logic [1:0]        m_status,
    output logic [6:0]        m_seconds,
    output logic [6:0]        m_minutes,
    output logic [6:0]        m_hours,
    output logic [6:0]        m_day,
    output logic signed [7:0] m_month,
    output logic [7:0]        m_year_since_1900
);

    logic    rec_valid;
    logic    rec_ready;
    record_t rec_data;
    logic    head_valid;
    logic    head_ready;
    record_t head_data;

    rmc_front #(
        .MAX_FIELDS (MAX_FIELDS),
        .FIELD_LEN  (FIELD_LEN)
    ) u_front (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .s_valid     (s_valid),
        .s_ready     (s_ready),
        .s_character (s_character),
        .s_last      (s_last),
        .rec_valid   (rec_valid),
        .rec_ready   (rec_ready),
        .rec_data    (rec_data)
    );

    rmc_queue u_queue (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .in_valid  (rec_valid),
        .in_ready  (rec_ready),
        .in_data   (rec_data),
        .out_valid (head_valid),
        .out_ready (head_ready),
        .out_data  (head_data)
    );

    rmc_back u_back (
        .aclk              (aclk),
        .aresetn           (aresetn),
        .in_valid          (head_valid),
        .in_ready          (head_ready),
        .in_data           (head_data),
        .m_valid           (m_valid),
        .m_ready           (m_ready),
        .m_status          (m_status),
        .m_seconds         (m_seconds),
        .m_minutes         (m_minutes),
        .m_hours           (m_hours),
        .m_day             (m_day),
        .m_month           (m_month),
        .m_year_since_1900 (m_year_since_1900)
    );

endmodule

// ===== rtl/rmc_front.sv =====
module rmc_front
    import rmc_pkg::*;
#(
    parameter int MAX_FIELDS = 16,
    parameter int FIELD_LEN  = 16
) (
    input  logic       aclk,
    input  logic       aresetn,
    input  logic       s_valid,
    output logic       s_ready,
    input  logic [7:0] s_character,
    input  logic       s_last,
    output logic       rec_valid,
    input  logic       rec_ready,
    output record_t    rec_data
);

    logic [4:0] field_index_reg, field_index_next;
    logic [3:0] char_pos_reg, char_pos_next;
    logic       time_full_reg, time_full_next;
    logic       date_full_reg, date_full_next;
    logic [CAPTURE_LEN-1:0][7:0] time_chars_reg;
    logic [CAPTURE_LEN-1:0][7:0] date_chars_reg;

    logic accept;
    logic active;
    logic is_comma;
    logic capture;
    logic time_hit;
    logic date_hit;
    logic pos_is_end;

    assign s_ready   = rec_ready;
    assign rec_valid = s_valid && s_last;
    assign accept    = s_valid && s_ready;

    assign active   = field_index_reg < 5'(MAX_FIELDS);
    assign is_comma = s_character == COMMA_CHAR;
    assign capture  = active && !is_comma && (char_pos_reg < 4'(FIELD_LEN - 1))
                      && (char_pos_reg < 4'(CAPTURE_LEN));
    assign time_hit   = capture && (field_index_reg == TIME_FIELD);
    assign date_hit   = capture && (field_index_reg == DATE_FIELD);
    assign pos_is_end = char_pos_reg == 4'(CAPTURE_LEN - 1);

    always_comb begin
        field_index_next = field_index_reg;
        char_pos_next    = char_pos_reg;
        time_full_next   = time_full_reg || (time_hit && pos_is_end);
        date_full_next   = date_full_reg || (date_hit && pos_is_end);
        if (active) begin
            if (is_comma) begin
                field_index_next = field_index_reg + 5'd1;
                char_pos_next    = '0;
            end else if (char_pos_reg < 4'(FIELD_LEN - 1)) begin
                char_pos_next = char_pos_reg + 4'd1;
            end
        end
        for (int i = 0; i < CAPTURE_LEN; i++) begin
            rec_data.time_chars[i] = (time_hit && char_pos_reg == 4'(i)) ?
                                     s_character : time_chars_reg[i];
            rec_data.date_chars[i] = (date_hit && char_pos_reg == 4'(i)) ?
                                     s_character : date_chars_reg[i];
        end
        rec_data.time_full = time_full_next;
        rec_data.date_full = date_full_next;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            field_index_reg <= '0;
            char_pos_reg    <= '0;
            time_full_reg   <= 1'b0;
            date_full_reg   <= 1'b0;
        end else if (accept) begin
            if (s_last) begin
                field_index_reg <= '0;
                char_pos_reg    <= '0;
                time_full_reg   <= 1'b0;
                date_full_reg   <= 1'b0;
            end else begin
                field_index_reg <= field_index_next;
                char_pos_reg    <= char_pos_next;
                time_full_reg   <= time_full_next;
                date_full_reg   <= date_full_next;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (accept && time_hit) begin
            time_chars_reg[char_pos_reg[2:0]] <= s_character;
        end
        if (accept && date_hit) begin
            date_chars_reg[char_pos_reg[2:0]] <= s_character;
        end
    end

endmodule

// ===== rtl/rmc_queue.sv =====
module rmc_queue
    import rmc_pkg::*;
(
    input  logic    aclk,
    input  logic    aresetn,
    input  logic    in_valid,
    output logic    in_ready,
    input  record_t in_data,
    output logic    out_valid,
    input  logic    out_ready,
    output record_t out_data
);

    record_t    entries_reg [2];
    logic       wr_ptr_reg;
    logic       rd_ptr_reg;
    logic [1:0] count_reg;
    logic       push;
    logic       pop;

    assign in_ready  = count_reg != 2'd2;
    assign out_valid = count_reg != 2'd0;
    assign out_data  = entries_reg[rd_ptr_reg];
    assign push      = in_valid && in_ready;
    assign pop       = out_valid && out_ready;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            count_reg  <= '0;
        end else begin
            if (push) begin
                wr_ptr_reg <= !wr_ptr_reg;
            end
            if (pop) begin
                rd_ptr_reg <= !rd_ptr_reg;
            end
            if (push && !pop) begin
                count_reg <= count_reg + 2'd1;
            end else if (pop && !push) begin
                count_reg <= count_reg - 2'd1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (push) begin
            entries_reg[wr_ptr_reg] <= in_data;
        end
    end

`ifndef ASSERT_OFF
    assert property (@(posedge aclk) disable iff (!aresetn) count_reg != 2'd3)
        else $error("queue count out of range");
    assert property (@(posedge aclk) disable iff (!aresetn)
        (count_reg == 2'd1 && !pop) |-> (wr_ptr_reg != rd_ptr_reg))
        else $error("queue pointers disagree with count");
    assert property (@(posedge aclk) disable iff (!aresetn)
        (push && !pop && count_reg == 2'd1) |=> !in_ready)
        else $error("queue not full after second entry");
`endif

endmodule

// ===== rtl/rmc_back.sv =====
module rmc_back
    import rmc_pkg::*;
(
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              in_valid,
    output logic              in_ready,
    input  record_t           in_data,
    output logic              m_valid,
    input  logic              m_ready,
    output logic [1:0]        m_status,
    output logic [6:0]        m_seconds,
    output logic [6:0]        m_minutes,
    output logic [6:0]        m_hours,
    output logic [6:0]        m_day,
    output logic signed [7:0] m_month,
    output logic [7:0]        m_year_since_1900
);

    function automatic logic is_digit(input logic [7:0] c);
        is_digit = (c >= ZERO_CHAR) && (c <= NINE_CHAR);
    endfunction

    // atoi over two characters: the first non-digit ends the value.
    function automatic logic [6:0] two_char_value(input logic [7:0] a, input logic [7:0] b);
        logic [6:0] da;
        logic [6:0] db;
        da = {3'b000, a[3:0]};
        db = {3'b000, b[3:0]};
        if (!is_digit(a)) begin
            two_char_value = '0;
        end else if (is_digit(b)) begin
            two_char_value = 7'(da * 7'd10) + db;
        end else begin
            two_char_value = da;
        end
    endfunction

    logic                valid_reg;
    status_t             status_reg, status_next;
    logic [6:0]          seconds_reg, seconds_next;
    logic [6:0]          minutes_reg, minutes_next;
    logic [6:0]          hours_reg, hours_next;
    logic [6:0]          day_reg, day_next;
    logic signed [7:0]   month_reg, month_next;
    logic [7:0]          year_reg, year_next;
    logic                load;

    assign in_ready = !valid_reg || m_ready;
    assign load     = in_valid && in_ready;

    always_comb begin
        status_next  = STATUS_OK;
        seconds_next = '0;
        minutes_next = '0;
        hours_next   = '0;
        day_next     = '0;
        month_next   = '0;
        year_next    = '0;
        if (!in_data.time_full) begin
            status_next = STATUS_TIME_SHORT;
        end else begin
            seconds_next = two_char_value(in_data.time_chars[4], in_data.time_chars[5]);
            minutes_next = two_char_value(in_data.time_chars[2], in_data.time_chars[3]);
            hours_next   = two_char_value(in_data.time_chars[0], in_data.time_chars[1]);
            if (!in_data.date_full) begin
                status_next = STATUS_DATE_SHORT;
            end else begin
                day_next   = two_char_value(in_data.date_chars[0], in_data.date_chars[1]);
                month_next = signed'({1'b0,
                    two_char_value(in_data.date_chars[2], in_data.date_chars[3])} - 8'd1);
                year_next  = {1'b0,
                    two_char_value(in_data.date_chars[4], in_data.date_chars[5])}
                    + YEAR_OFFSET;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else if (load) begin
            valid_reg <= 1'b1;
        end else if (m_ready) begin
            valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (load) begin
            status_reg  <= status_next;
            seconds_reg <= seconds_next;
            minutes_reg <= minutes_next;
            hours_reg   <= hours_next;
            day_reg     <= day_next;
            month_reg   <= month_next;
            year_reg    <= year_next;
        end
    end

    assign m_valid           = valid_reg;
    assign m_status          = status_reg;
    assign m_seconds         = seconds_reg;
    assign m_minutes         = minutes_reg;
    assign m_hours           = hours_reg;
    assign m_day             = day_reg;
    assign m_month           = month_reg;
    assign m_year_since_1900 = year_reg;

`ifndef ASSERT_OFF
    assert property (@(posedge aclk) disable iff (!aresetn) load |=> valid_reg)
        else $error("loaded result not presented");
    assert property (@(posedge aclk) disable iff (!aresetn)
        (valid_reg && status_reg == STATUS_TIME_SHORT) |->
        (seconds_reg == 7'd0 && minutes_reg == 7'd0 && hours_reg == 7'd0
         && day_reg == 7'd0 && month_reg == 8'sd0 && year_reg == 8'd0))
        else $error("short time with nonzero fields");
    assert property (@(posedge aclk) disable iff (!aresetn)
        (valid_reg && status_reg == STATUS_DATE_SHORT) |->
        (day_reg == 7'd0 && month_reg == 8'sd0 && year_reg == 8'd0))
        else $error("short date with nonzero date fields");
`endif

endmodule
